@@ design/bpec_pkg.sv @@
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared types and constants of the button press event classifier.
// ----------------------------------------------------------------------------
package bpec_pkg;

  // field widths
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ClickW     = 8;
  localparam int unsigned MaxEvents  = 3;
  localparam int unsigned EvtCntW    = 2;

  // input operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEVEL = 2'd1,
    OP_LOCK  = 2'd2
  } op_e;

  // event kinds
  typedef enum logic [2:0] {
    KIND_SHORT_PRESS   = 3'd0,
    KIND_SHORT_RELEASE = 3'd1,
    KIND_LONG_PRESS    = 3'd2,
    KIND_LONG_RELEASE  = 3'd3,
    KIND_EXTRA_PRESS   = 3'd4,
    KIND_EXTRA_RELEASE = 3'd5,
    KIND_MULTI_CLICK   = 3'd6
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_MODE  = 3'd0,
    CFG_LONG_HOLD     = 3'd1,
    CFG_EXTRA_HOLD    = 3'd2,
    CFG_CLICK_QUIET   = 3'd3,
    CFG_LONG_EN       = 3'd4,
    CFG_EXTRA_EN      = 3'd5,
    CFG_LOCK_POLARITY = 3'd6
  } cfg_idx_e;

  // channel modes and lock polarities
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_MULTI    = 2'd3;
  localparam logic [1:0] LOCK_HIGH     = 2'd1;
  localparam logic [1:0] LOCK_LOW      = 2'd2;

  localparam logic [ClickW-1:0] ClickMax = '1;

  // reset values of the hold and quiet times
  localparam logic [CfgWidth-1:0] LongHoldRst  = 16'd500;
  localparam logic [CfgWidth-1:0] ExtraHoldRst = 16'd2000;
  localparam logic [CfgWidth-1:0] QuietRst     = 16'd300;

  // one event
  typedef struct packed {
    logic              button;
    kind_e             kind;
    logic [ClickW-1:0] clicks;
  } evt_t;

  // all events caused by one input transaction
  typedef struct packed {
    logic [EvtCntW-1:0]       count;
    evt_t [MaxEvents-1:0]     ev;
  } batch_t;

  // handshake between producer and consumer of the batch queue
  typedef struct packed {
    logic   valid;
    batch_t batch;
  } push_t;

endpackage

@@ design/bpec_if.sv @@
// ----------------------------------------------------------------------------
// bpec_in_if / bpec_out_if
// Valid/ready channels for input transactions and event transactions.
// ----------------------------------------------------------------------------
interface bpec_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       which_button;
  logic       level;

  modport source (output valid, operation, which_button, level, input ready);
  modport sink   (input valid, operation, which_button, level, output ready);
endinterface

interface bpec_out_if;
  logic       valid;
  logic       ready;
  logic       event_button;
  logic [2:0] event_kind;
  logic [7:0] click_total;
  logic       last_event;

  modport source (output valid, event_button, event_kind, click_total, last_event,
                  input ready);
  modport sink   (input valid, event_button, event_kind, click_total, last_event,
                  output ready);
endinterface

@@ design/bpec_front.sv @@
// ----------------------------------------------------------------------------
// bpec_front
// Configuration registers, button state and classification of one input
// transaction per cycle (queue not full) into a batch of up to three events.
// ----------------------------------------------------------------------------
module bpec_front #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpec_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bpec_pkg::CfgWidth-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic [1:0]                        in_operation_i,
  input  logic                              in_which_button_i,
  input  logic                              in_level_i,
  input  logic                              q_full_i,
  output logic                              in_ready_o,
  output bpec_pkg::push_t                   push_o
);
  import bpec_pkg::*;

  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned CW = (TW > CfgWidth) ? TW : CfgWidth;

  // configuration registers
  logic [1:0]          mode_q;
  logic [CfgWidth-1:0] long_hold_q, extra_hold_q, quiet_q;
  logic                long_en_q, extra_en_q;
  logic [1:0]          lock_pol_q;

  // button and click state
  logic [1:0]          pressed_q, pressed_d;
  logic [1:0]          long_q, long_d;
  logic [1:0]          extra_q, extra_d;
  logic [TW-1:0]       hold_q [2];
  logic [TW-1:0]       hold_d [2];
  logic [ClickW-1:0]   click_cnt_q, click_cnt_d;
  logic                click_run_q, click_run_d;
  logic [TW-1:0]       click_el_q, click_el_d;
  logic                locked_q, locked_d;

  logic                accept;
  logic [MaxEvents-1:0] cand_v;
  evt_t                cand_e [MaxEvents];
  batch_t              batch;
  logic [EvtCntW-1:0]  n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_DISABLED;
      long_hold_q  <= LongHoldRst;
      extra_hold_q <= ExtraHoldRst;
      quiet_q      <= QuietRst;
      long_en_q    <= 1'b0;
      extra_en_q   <= 1'b0;
      lock_pol_q   <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_MODE:  mode_q       <= cfg_wdata_i[1:0];
        CFG_LONG_HOLD:     long_hold_q  <= cfg_wdata_i;
        CFG_EXTRA_HOLD:    extra_hold_q <= cfg_wdata_i;
        CFG_CLICK_QUIET:   quiet_q      <= cfg_wdata_i;
        CFG_LONG_EN:       long_en_q    <= cfg_wdata_i[0];
        CFG_EXTRA_EN:      extra_en_q   <= cfg_wdata_i[0];
        CFG_LOCK_POLARITY: lock_pol_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // next state and event candidates
  always_comb begin
    logic [TW-1:0] h_inc;
    logic [TW-1:0] c_inc;
    logic          b;
    pressed_d   = pressed_q;
    long_d      = long_q;
    extra_d     = extra_q;
    hold_d      = hold_q;
    click_cnt_d = click_cnt_q;
    click_run_d = click_run_q;
    click_el_d  = click_el_q;
    locked_d    = locked_q;
    cand_v      = '0;
    for (int i = 0; i < MaxEvents; i++) begin
      cand_e[i] = '{button: 1'b0, kind: KIND_SHORT_PRESS, clicks: '0};
    end
    b     = in_which_button_i;
    h_inc = '0;
    c_inc = '0;

    case (in_operation_i)
      OP_TICK: begin
        // hold check of each button, A first
        for (int k = 0; k < 2; k++) begin
          if (pressed_q[k]) begin
            h_inc     = (hold_q[k] == '1) ? hold_q[k] : hold_q[k] + TW'(1);
            hold_d[k] = h_inc;
            if (long_en_q || extra_en_q) begin
              if (!long_q[k] && CW'(h_inc) >= CW'(long_hold_q)) begin
                long_d[k] = 1'b1;
                cand_v[k] = 1'b1;
                cand_e[k] = '{button: k[0], kind: KIND_LONG_PRESS, clicks: '0};
              end else if (extra_en_q && !extra_q[k] &&
                           CW'(h_inc) >= CW'(extra_hold_q)) begin
                extra_d[k] = 1'b1;
                cand_v[k]  = 1'b1;
                cand_e[k]  = '{button: k[0], kind: KIND_EXTRA_PRESS, clicks: '0};
              end
            end
          end
        end
        // quiet time after clicks of button A
        if (mode_q == MODE_MULTI && !pressed_q[0] && click_run_q) begin
          c_inc = (click_el_q == '1) ? click_el_q : click_el_q + TW'(1);
          if (CW'(c_inc) >= CW'(quiet_q)) begin
            cand_v[2]   = 1'b1;
            cand_e[2]   = '{button: 1'b0, kind: KIND_MULTI_CLICK, clicks: click_cnt_q};
            click_run_d = 1'b0;
            click_el_d  = '0;
            click_cnt_d = '0;
          end else begin
            click_el_d = c_inc;
          end
        end
      end
      OP_LEVEL: begin
        if (mode_q != MODE_DISABLED && pressed_q[b] != in_level_i) begin
          if (in_level_i) begin
            // press
            if (!locked_q) begin
              if (mode_q == MODE_MULTI && !b) begin
                if (click_cnt_q != ClickMax) click_cnt_d = click_cnt_q + ClickW'(1);
                click_run_d = 1'b1;
                click_el_d  = '0;
              end else begin
                cand_v[0] = 1'b1;
                cand_e[0] = '{button: b, kind: KIND_SHORT_PRESS, clicks: '0};
              end
              pressed_d[b] = 1'b1;
              long_d[b]    = 1'b0;
              extra_d[b]   = 1'b0;
              hold_d[b]    = '0;
            end
          end else begin
            // release, reported at the deepest level reached
            if (extra_q[b]) begin
              cand_v[0] = 1'b1;
              cand_e[0] = '{button: b, kind: KIND_EXTRA_RELEASE, clicks: '0};
            end else if (long_q[b]) begin
              cand_v[0] = 1'b1;
              cand_e[0] = '{button: b, kind: KIND_LONG_RELEASE, clicks: '0};
            end else if (mode_q == MODE_MULTI) begin
              if (!b) begin
                click_run_d = 1'b1;
                click_el_d  = '0;
              end
            end else begin
              cand_v[0] = 1'b1;
              cand_e[0] = '{button: b, kind: KIND_SHORT_RELEASE, clicks: '0};
            end
            if ((extra_q[b] || long_q[b]) && !b) begin
              click_cnt_d = '0;
              click_run_d = 1'b0;
              click_el_d  = '0;
            end
            pressed_d[b] = 1'b0;
            long_d[b]    = 1'b0;
            extra_d[b]   = 1'b0;
            hold_d[b]    = '0;
          end
        end
      end
      OP_LOCK: begin
        if (mode_q != MODE_DISABLED && (lock_pol_q == LOCK_HIGH || lock_pol_q == LOCK_LOW)) begin
          locked_d    = in_level_i ^ (lock_pol_q == LOCK_LOW);
          pressed_d   = '0;
          long_d      = '0;
          extra_d     = '0;
          hold_d[0]   = '0;
          hold_d[1]   = '0;
          click_cnt_d = '0;
          click_run_d = 1'b0;
          click_el_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // pack the candidates in order into one batch
  always_comb begin
    batch = '0;
    n     = '0;
    for (int i = 0; i < MaxEvents; i++) begin
      if (cand_v[i]) begin
        batch.ev[n] = cand_e[i];
        n           = n + EvtCntW'(1);
      end
    end
    batch.count = n;
  end

  assign push_o.valid = accept && (cand_v != '0);
  assign push_o.batch = batch;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q   <= '0;
      long_q      <= '0;
      extra_q     <= '0;
      hold_q[0]   <= '0;
      hold_q[1]   <= '0;
      click_cnt_q <= '0;
      click_run_q <= 1'b0;
      click_el_q  <= '0;
      locked_q    <= 1'b0;
    end else if (accept) begin
      pressed_q   <= pressed_d;
      long_q      <= long_d;
      extra_q     <= extra_d;
      hold_q[0]   <= hold_d[0];
      hold_q[1]   <= hold_d[1];
      click_cnt_q <= click_cnt_d;
      click_run_q <= click_run_d;
      click_el_q  <= click_el_d;
      locked_q    <= locked_d;
    end
  end

endmodule

@@ design/bpec_queue.sv @@
// ----------------------------------------------------------------------------
// bpec_queue
// Two-entry queue of event batches between classifier and serializer.
// ----------------------------------------------------------------------------
module bpec_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpec_pkg::push_t  push_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output bpec_pkg::batch_t batch_o
);
  import bpec_pkg::*;

  batch_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign batch_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.batch;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/bpec_back.sv @@
// ----------------------------------------------------------------------------
// bpec_back
// Serializer: takes one batch from the queue and sends its events one per
// transaction, flagging the final one.
// ----------------------------------------------------------------------------
module bpec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  bpec_pkg::batch_t q_batch_i,
  output logic             q_pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output bpec_pkg::evt_t   out_evt_o,
  output logic             out_last_o
);
  import bpec_pkg::*;

  logic               busy_q;
  batch_t             cur_q;
  logic [EvtCntW-1:0] idx_q;
  logic               fire, load;

  assign out_valid_o = busy_q;
  assign out_evt_o   = cur_q.ev[idx_q];
  assign out_last_o  = (idx_q == cur_q.count - EvtCntW'(1));
  assign fire        = busy_q && out_ready_i;
  assign load        = (!busy_q || (fire && out_last_o)) && !q_empty_i;
  assign q_pop_o     = load;

  // current batch
  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_batch_i;
  end

  // event pointer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      if (out_last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + EvtCntW'(1);
      end
    end
  end

endmodule

@@ design/button_press_event_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button_press_event_classifier_unit
// Classifies ticks, button level changes and lock changes of two buttons
// into press, release, hold and multi-click events.
//
// channel | dir | handshake          | payload
// in_i    | in  | valid/ready        | operation, which_button, level
// out_o   | out | valid/ready        | event_button, event_kind, click_total,
//         |     |                    | last_event
// cfg     | in  | cfg_we_i (no wait) | cfg_idx_i, cfg_wdata_i
//
// An input transaction is classified in the cycle it is accepted; the
// classifier takes one per cycle while the two-entry batch queue has room.
// Events leave the serializer register one per cycle while out_o is ready, so
// an input causing k events (up to three) takes k output transactions.
// Input ready drops only while the queue is full; no clearing pass after reset.
// ----------------------------------------------------------------------------
module button_press_event_classifier_unit #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpec_pkg::CfgWidth-1:0] cfg_wdata_i,
  bpec_in_if.sink                       in_i,
  bpec_out_if.source                    out_o
);
  import bpec_pkg::*;

  push_t  push;
  batch_t q_batch;
  logic   q_full, q_empty, q_pop;
  evt_t   evt;
  logic   last;

  // classifier
  bpec_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_i.valid),
    .in_operation_i    (in_i.operation),
    .in_which_button_i (in_i.which_button),
    .in_level_i        (in_i.level),
    .q_full_i          (q_full),
    .in_ready_o        (in_i.ready),
    .push_o            (push)
  );

  // batch queue
  bpec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .batch_o (q_batch)
  );

  // serializer
  bpec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_batch_i   (q_batch),
    .q_pop_o     (q_pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_evt_o   (evt),
    .out_last_o  (last)
  );

  // output payload
  assign out_o.event_button = evt.button;
  assign out_o.event_kind   = evt.kind;
  assign out_o.click_total  = evt.clicks;
  assign out_o.last_event   = last;

endmodule
